/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the trie prefix counter checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* sv/tpc_pkg.sv */
// ----------------------------------------------------------------------------
// tpc_pkg
// Word types, operation and status codes, and controller/datapath interface
// structs for the trie prefix counter.
// ----------------------------------------------------------------------------
`default_nettype none

package tpc_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam int                       COUNT_OUT_BITS = 16;
   localparam logic [COUNT_OUT_BITS-1:0] COUNT_OUT_MAX = '1;

   typedef struct packed {
      logic [1:0] operation;
      logic [4:0] letter;
      logic       last_letter;
   } req_word_type;

   typedef struct packed {
      logic [COUNT_OUT_BITS-1:0] word_count;
      logic [1:0]                status;
   } rsp_word_type;

   typedef struct packed {
      logic accept;
      logic start_clear;
      logic sweep_step;
      logic alloc;
      logic set_full;
      logic set_missed;
      logic advance;
      logic cnt_read;
      logic cnt_write;
      logic final_read;
      logic emit;
   } tpc_cmd_type;

   typedef struct packed {
      logic [1:0] req_op;
      logic       item_insert;
      logic       item_last;
      logic       halted;
      logic       letter_bad;
      logic       kid_zero;
      logic       table_full;
      logic       sweep_last;
      logic       rsp_free;
   } tpc_stat_type;

endpackage

`default_nettype wire

/* sv/tpc_datapath.sv */
// ----------------------------------------------------------------------------
// tpc_datapath
// Link and count memories, walk state, clearing sweep and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tpc_datapath #(
   parameter int NODE_COUNT = 4096,
   parameter int ALPHABET   = 26,
   parameter int COUNT_BITS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire  tpc_pkg::req_word_type  req_word,
   input  wire  tpc_pkg::tpc_cmd_type   cmd,
   output tpc_pkg::tpc_stat_type        stat,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output tpc_pkg::rsp_word_type        rsp_word
);

   localparam int NODE_BITS  = $clog2(NODE_COUNT);
   localparam int FREE_BITS  = $clog2(NODE_COUNT + 1);
   localparam int LINK_DEPTH = NODE_COUNT * ALPHABET;
   localparam int LADDR_BITS = $clog2(LINK_DEPTH);
   localparam int SWEEP_BITS = $clog2(LINK_DEPTH + 1);
   localparam int WIDE_BITS  = SWEEP_BITS + 6;

   logic [NODE_BITS-1:0]  link_mem [LINK_DEPTH];
   logic [COUNT_BITS-1:0] count_mem [NODE_COUNT];

   logic [NODE_BITS-1:0]  link_rd_ff;
   logic [COUNT_BITS-1:0] count_rd_ff;
   logic [LADDR_BITS-1:0] slot_ff;
   logic                  insert_ff;
   logic                  last_ff;
   logic                  bad_ff;

   logic [NODE_BITS-1:0]  cur_ff, cur_in;
   logic [FREE_BITS-1:0]  free_ff, free_in;
   logic                  missed_ff, missed_in;
   logic                  full_ff, full_in;
   logic [SWEEP_BITS-1:0] sweep_ff, sweep_in;
   logic [SWEEP_BITS-1:0] sweep_end_ff, sweep_end_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   tpc_pkg::rsp_word_type rsp_word_ff;

   logic [WIDE_BITS-1:0]             slot_wide;
   logic [SWEEP_BITS-1:0]            sweep_end_next;
   logic [COUNT_BITS-1:0]            count_inc;
   logic [31:0]                      count_wide;
   logic [tpc_pkg::COUNT_OUT_BITS-1:0] count_clamp;
   logic                             letter_bad;

   assign slot_wide = WIDE_BITS'(cur_ff) * WIDE_BITS'(ALPHABET)
                    + WIDE_BITS'(req_word.letter);
   assign sweep_end_next = SWEEP_BITS'(SWEEP_BITS'(free_ff) * SWEEP_BITS'(ALPHABET));
   assign letter_bad = 7'(req_word.letter) >= 7'(ALPHABET);
   assign count_inc = (&count_rd_ff) ? count_rd_ff : count_rd_ff + COUNT_BITS'(1);
   assign count_wide = 32'(count_rd_ff);
   assign count_clamp = (count_wide > 32'(tpc_pkg::COUNT_OUT_MAX)) ?
                        tpc_pkg::COUNT_OUT_MAX : count_wide[tpc_pkg::COUNT_OUT_BITS-1:0];

   // link memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.sweep_step) begin
         link_mem[sweep_ff[LADDR_BITS-1:0]] <= '0;
      end else if (cmd.alloc) begin
         link_mem[slot_ff] <= free_ff[NODE_BITS-1:0];
      end
      if (cmd.accept) begin
         link_rd_ff <= link_mem[slot_wide[LADDR_BITS-1:0]];
      end
   end

   // count memory
   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         count_mem[free_ff[NODE_BITS-1:0]] <= COUNT_BITS'(1);
      end else if (cmd.cnt_write) begin
         count_mem[link_rd_ff] <= count_inc;
      end
      if (cmd.cnt_read) begin
         count_rd_ff <= count_mem[link_rd_ff];
      end else if (cmd.final_read) begin
         count_rd_ff <= count_mem[cur_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         slot_ff   <= slot_wide[LADDR_BITS-1:0];
         insert_ff <= req_word.operation == tpc_pkg::OP_INSERT;
         last_ff   <= req_word.last_letter;
         bad_ff    <= letter_bad;
      end
      if (cmd.emit) begin
         if (full_ff) begin
            rsp_word_ff.status     <= tpc_pkg::STATUS_FULL;
            rsp_word_ff.word_count <= '0;
         end else if (missed_ff) begin
            rsp_word_ff.status     <= tpc_pkg::STATUS_MISS;
            rsp_word_ff.word_count <= '0;
         end else begin
            rsp_word_ff.status     <= tpc_pkg::STATUS_OK;
            rsp_word_ff.word_count <= (cur_ff == '0) ? '0 : count_clamp;
         end
      end
   end

   always_comb begin
      cur_in       = cur_ff;
      free_in      = free_ff;
      missed_in    = missed_ff;
      full_in      = full_ff;
      sweep_in     = sweep_ff;
      sweep_end_in = sweep_end_ff;
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
      if (cmd.start_clear) begin
         cur_in       = '0;
         free_in      = FREE_BITS'(1);
         missed_in    = 1'b0;
         full_in      = 1'b0;
         sweep_in     = '0;
         sweep_end_in = sweep_end_next;
      end
      if (cmd.sweep_step) begin
         sweep_in = sweep_ff + SWEEP_BITS'(1);
      end
      if (cmd.alloc) begin
         cur_in  = free_ff[NODE_BITS-1:0];
         free_in = free_ff + FREE_BITS'(1);
      end
      if (cmd.advance || cmd.cnt_write) begin
         cur_in = link_rd_ff;
      end
      if (cmd.set_full) begin
         full_in = 1'b1;
      end
      if (cmd.set_missed) begin
         missed_in = 1'b1;
      end
      if (cmd.emit) begin
         cur_in    = '0;
         missed_in = 1'b0;
         full_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         free_ff      <= FREE_BITS'(1);
         missed_ff    <= 1'b0;
         full_ff      <= 1'b0;
         sweep_ff     <= '0;
         sweep_end_ff <= SWEEP_BITS'(LINK_DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         free_ff      <= free_in;
         missed_ff    <= missed_in;
         full_ff      <= full_in;
         sweep_ff     <= sweep_in;
         sweep_end_ff <= sweep_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.req_op      = req_word.operation;
   assign stat.item_insert = insert_ff;
   assign stat.item_last   = last_ff;
   assign stat.halted      = missed_ff || full_ff;
   assign stat.letter_bad  = bad_ff;
   assign stat.kid_zero    = link_rd_ff == '0;
   assign stat.table_full  = free_ff == FREE_BITS'(NODE_COUNT);
   assign stat.sweep_last  = sweep_ff == sweep_end_ff - SWEEP_BITS'(1);
   assign stat.rsp_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

/* sv/tpc_controller.sv */
// ----------------------------------------------------------------------------
// tpc_controller
// Sequencer for letter steps, result hand-off and the clearing sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module tpc_controller (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  tpc_pkg::tpc_stat_type  stat,
   output tpc_pkg::tpc_cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_CNTUPD = 3'd2;
   localparam logic [2:0] ST_FINAL  = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;
   localparam logic [2:0] ST_CLEAR  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [2:0] after_step;

   assign after_step = stat.item_last ? ST_FINAL : ST_IDLE;
   assign req_stall  = state_ff != ST_IDLE;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               priority if (stat.req_op == tpc_pkg::OP_CLEAR) begin
                  cmd.start_clear = 1'b1;
                  state_in        = ST_CLEAR;
               end else if (stat.req_op == tpc_pkg::OP_INSERT ||
                            stat.req_op == tpc_pkg::OP_QUERY) begin
                  state_in = ST_DECIDE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DECIDE: begin
            state_in = after_step;
            if (stat.item_insert) begin
               priority if (stat.halted || stat.letter_bad) begin
                  state_in = after_step;
               end else if (stat.kid_zero) begin
                  cmd.set_full = stat.table_full;
                  cmd.alloc    = !stat.table_full;
               end else begin
                  cmd.cnt_read = 1'b1;
                  state_in     = ST_CNTUPD;
               end
            end else begin
               priority if (stat.halted) begin
                  state_in = after_step;
               end else if (stat.letter_bad || stat.kid_zero) begin
                  cmd.set_missed = 1'b1;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         ST_CNTUPD: begin
            cmd.cnt_write = 1'b1;
            state_in      = after_step;
         end
         ST_FINAL: begin
            cmd.final_read = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* sv/trie_prefix_counter_unit.sv */
// ----------------------------------------------------------------------------
// trie_prefix_counter_unit
// Prefix-count trie of lower-case words, one letter per input word.
// ----------------------------------------------------------------------------
// A letter that moves the walk or allocates a node is accepted with the link
// read, then decided and written; an insert through an existing node adds a
// count read before its saturating write. The marked last letter adds the
// count read and the result load, which waits while a held result stalls.
// All of this is set by the registered read port of the link and count
// memories. After reset the link memory is swept, one entry per cycle, over
// all NODE_COUNT*ALPHABET entries (106496 by default); a clear sweeps only
// the entries in use, next-free-node * ALPHABET of them. req_stall is high
// during both. A finished result sits in the output register while the
// next letter is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module trie_prefix_counter_unit #(
   parameter int NODE_COUNT = 4096,
   parameter int ALPHABET   = 26,
   parameter int COUNT_BITS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  tpc_pkg::req_word_type  req_word,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output tpc_pkg::rsp_word_type        rsp_word
);

   tpc_pkg::tpc_cmd_type  cmd;
   tpc_pkg::tpc_stat_type stat;

   tpc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   tpc_datapath #(
      .NODE_COUNT (NODE_COUNT),
      .ALPHABET   (ALPHABET),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

/* sv/tpc_checker.sv */
// ----------------------------------------------------------------------------
// tpc_checker
// Port-level assertions for the trie prefix counter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tpc_checker (
   input wire                         clock,
   input wire                         reset,
   input wire                         req_valid,
   input wire                         req_stall,
   input wire tpc_pkg::req_word_type  req_word,
   input wire                         rsp_valid,
   input wire                         rsp_stall,
   input wire tpc_pkg::rsp_word_type  rsp_word
);

   logic req_take;
   logic rsp_held;
   logic rsp_fail;
   logic req_walk;

   assign req_take = req_valid && !req_stall;
   assign rsp_held = rsp_valid && rsp_stall;
   assign rsp_fail = rsp_valid && rsp_word.status != tpc_pkg::STATUS_OK;
   assign req_walk = req_take && (req_word.operation == tpc_pkg::OP_INSERT ||
                                  req_word.operation == tpc_pkg::OP_QUERY  ||
                                  req_word.operation == tpc_pkg::OP_CLEAR);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_word))
   `ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_fail, rsp_word.word_count == '0)
   `ASSERT_IMPLY(a_sweep_after_reset, clock, 1'b0, $fell(reset), req_stall)
   `ASSERT_NEXT(a_busy_after_take, clock, reset, req_walk, req_stall)

endmodule

bind trie_prefix_counter_unit tpc_checker u_tpc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

`default_nettype wire
